>>> rtl/core/oomvs_pkg.sv
package oomvs_pkg;

    localparam int PID_W    = 15;
    localparam int FRAMES_W = 32;
    localparam int COUNT_W  = 6;
    localparam int DEC_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // slave tdata: task_live, task_pid, resident_frames, has_window, immune,
    // marked_dying, requester_pid, zero fill
    localparam int S_TDATA_W = 72;
    // master tdata: decision, already_marked, victim_pid, victim_frames,
    // victim_window, spared_window_task, eligible_count, live_count
    localparam int M_TDATA_W = 64;

    localparam int DEF_MAX_TASKS = 32;

    localparam logic [FRAMES_W-1:0] RESET_MIN_VICTIM = 32'd64;
    localparam logic [FRAMES_W-1:0] RESET_ENOUGH     = 32'd512;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_VICTIM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENOUGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEWEST     = 2'd2;

    localparam logic [DEC_W-1:0] DEC_NONE  = 2'd0;
    localparam logic [DEC_W-1:0] DEC_OTHER = 2'd1;
    localparam logic [DEC_W-1:0] DEC_SELF  = 2'd2;

endpackage

>>> rtl/core/oom_victim_selector.sv
// channel | dir | handshake                   | payload
// s       | in  | i_s_tvalid / o_s_tready     | i_s_tdata (one table slot), i_s_tlast = last_slot
// m       | out | o_m_tvalid / i_m_tready     | o_m_tdata (one decision per table)
// cfg     | in  | i_cfg_we (no handshake)     | i_cfg_idx, i_cfg_data
//
// one slot is taken per cycle while o_s_tready is high; the decision for a table appears in the output
// register the cycle after its last slot is taken
// the running maxima and counts are updated by a single compare each per slot
// synchronous active-low reset clears counts, flags, output valid and config
// o_s_tready is low only while a decision waits in the output register and
// i_m_tready is low
module oom_victim_selector #(
    parameter int MAX_TASKS = oomvs_pkg::DEF_MAX_TASKS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [oomvs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [oomvs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // task_live [0], task_pid [15:1], resident_frames [47:16], has_window [48],
    // immune [49], marked_dying [50], requester_pid [65:51], zero [71:66]
    input  logic [oomvs_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // decision [1:0], already_marked [2], victim_pid [17:3],
    // victim_frames [49:18], victim_window [50], spared_window_task [51],
    // eligible_count [57:52], live_count [63:58]
    output logic [oomvs_pkg::M_TDATA_W-1:0]   o_m_tdata
);
    import oomvs_pkg::*;

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TASKS);

    // configuration
    logic [FRAMES_W-1:0] r_min_victim;
    logic [FRAMES_W-1:0] r_enough;
    logic                r_newest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_victim <= RESET_MIN_VICTIM;
            r_enough     <= RESET_ENOUGH;
            r_newest     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_VICTIM: r_min_victim <= i_cfg_data[FRAMES_W-1:0];
                REG_ENOUGH:     r_enough     <= i_cfg_data[FRAMES_W-1:0];
                REG_NEWEST:     r_newest     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // slot fields
    logic                in_live, in_win, in_imm, in_dying;
    logic [PID_W-1:0]    in_pid, in_req;
    logic [FRAMES_W-1:0] in_frames;

    assign in_live   = i_s_tdata[0];
    assign in_pid    = i_s_tdata[15:1];
    assign in_frames = i_s_tdata[47:16];
    assign in_win    = i_s_tdata[48];
    assign in_imm    = i_s_tdata[49];
    assign in_dying  = i_s_tdata[50];
    assign in_req    = i_s_tdata[65:51];

    // running state
    logic [CW-1:0]       r_live_seen, n_live_seen;
    logic [CW-1:0]       r_elig_seen, n_elig_seen;
    logic                r_marked_found, n_marked_found;
    logic [PID_W-1:0]    r_marked_pid, n_marked_pid;
    logic [FRAMES_W-1:0] r_marked_frames, n_marked_frames;
    logic                r_marked_window, n_marked_window;
    logic                r_best_valid, n_best_valid;
    logic [PID_W-1:0]    r_best_pid, n_best_pid;
    logic [FRAMES_W-1:0] r_best_frames, n_best_frames;
    logic                r_best_window, n_best_window;
    logic                r_hl_valid, n_hl_valid;
    logic [PID_W-1:0]    r_hl_pid, n_hl_pid;
    logic [FRAMES_W-1:0] r_hl_frames, n_hl_frames;

    // output register
    logic                r_out_valid;
    logic [DEC_W-1:0]    r_decision, n_decision;
    logic                r_already, n_already;
    logic [PID_W-1:0]    r_vpid, n_vpid;
    logic [FRAMES_W-1:0] r_vframes, n_vframes;
    logic                r_vwin, n_vwin;
    logic                r_spared, n_spared;
    logic [CW-1:0]       r_out_elig, r_out_live;

    logic s_xfer, m_xfer, eligible, take, spare;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = r_out_valid && i_m_tready;

    always_comb begin
        n_live_seen     = r_live_seen;
        n_elig_seen     = r_elig_seen;
        n_marked_found  = r_marked_found;
        n_marked_pid    = r_marked_pid;
        n_marked_frames = r_marked_frames;
        n_marked_window = r_marked_window;
        n_best_valid    = r_best_valid;
        n_best_pid      = r_best_pid;
        n_best_frames   = r_best_frames;
        n_best_window   = r_best_window;
        n_hl_valid      = r_hl_valid;
        n_hl_pid        = r_hl_pid;
        n_hl_frames     = r_hl_frames;

        eligible = in_live && !in_imm && (in_frames >= r_min_victim);
        if (r_newest) begin
            take = !r_best_valid || (in_pid > r_best_pid);
        end else begin
            take = !r_best_valid || (in_frames > r_best_frames);
        end

        if (in_live) begin
            if (r_live_seen < CNT_MAX) begin
                n_live_seen = r_live_seen + 1'b1;
            end
            if (!in_imm && in_dying && !r_marked_found) begin
                n_marked_found  = 1'b1;
                n_marked_pid    = in_pid;
                n_marked_frames = in_frames;
                n_marked_window = in_win;
            end
        end
        if (eligible) begin
            if (r_elig_seen < CNT_MAX) begin
                n_elig_seen = r_elig_seen + 1'b1;
            end
            if (take) begin
                n_best_valid  = 1'b1;
                n_best_pid    = in_pid;
                n_best_frames = in_frames;
                n_best_window = in_win;
            end
            if (!in_win && (!r_hl_valid || (in_frames > r_hl_frames))) begin
                n_hl_valid  = 1'b1;
                n_hl_pid    = in_pid;
                n_hl_frames = in_frames;
            end
        end

        // decision from the state as it stands after this slot
        n_decision = DEC_NONE;
        n_already  = 1'b0;
        n_vpid     = '0;
        n_vframes  = '0;
        n_vwin     = 1'b0;
        n_spared   = 1'b0;
        spare      = !r_newest && n_best_window && n_hl_valid && (n_hl_frames >= r_enough);
        if (n_live_seen != '0) begin
            if (n_marked_found) begin
                n_already  = 1'b1;
                n_vpid     = n_marked_pid;
                n_vframes  = n_marked_frames;
                n_vwin     = n_marked_window;
                n_decision = (n_marked_pid == in_req) ? DEC_SELF : DEC_OTHER;
            end else if (n_best_valid) begin
                if (spare) begin
                    n_vpid    = n_hl_pid;
                    n_vframes = n_hl_frames;
                    n_spared  = 1'b1;
                end else begin
                    n_vpid    = n_best_pid;
                    n_vframes = n_best_frames;
                    n_vwin    = n_best_window;
                end
                n_decision = (n_vpid == in_req) ? DEC_SELF : DEC_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live_seen    <= '0;
            r_elig_seen    <= '0;
            r_marked_found <= 1'b0;
            r_best_valid   <= 1'b0;
            r_hl_valid     <= 1'b0;
        end else if (s_xfer) begin
            if (i_s_tlast) begin
                r_live_seen    <= '0;
                r_elig_seen    <= '0;
                r_marked_found <= 1'b0;
                r_best_valid   <= 1'b0;
                r_hl_valid     <= 1'b0;
            end else begin
                r_live_seen    <= n_live_seen;
                r_elig_seen    <= n_elig_seen;
                r_marked_found <= n_marked_found;
                r_best_valid   <= n_best_valid;
                r_hl_valid     <= n_hl_valid;
            end
        end
    end

    // payload of the running maxima and the marked task, qualified by the flags above
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_marked_pid    <= n_marked_pid;
            r_marked_frames <= n_marked_frames;
            r_marked_window <= n_marked_window;
            r_best_pid      <= n_best_pid;
            r_best_frames   <= n_best_frames;
            r_best_window   <= n_best_window;
            r_hl_pid        <= n_hl_pid;
            r_hl_frames     <= n_hl_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_xfer && i_s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer && i_s_tlast) begin
            r_decision <= n_decision;
            r_already  <= n_already;
            r_vpid     <= n_vpid;
            r_vframes  <= n_vframes;
            r_vwin     <= n_vwin;
            r_spared   <= n_spared;
            r_out_elig <= n_elig_seen;
            r_out_live <= n_live_seen;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {COUNT_W'(r_out_live), COUNT_W'(r_out_elig), r_spared, r_vwin,
                         r_vframes, r_vpid, r_already, r_decision};

`ifndef NO_ASSERTIONS
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && i_s_tlast) |=> (r_live_seen == '0 && !r_best_valid && !r_marked_found))
        else $error("running state not cleared after last slot");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_decision == DEC_NONE) |-> (r_vpid == '0 && !r_already && !r_spared))
        else $error("no-victim decision carries victim data");

    a_spared_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_spared) |-> (!r_already && !r_vwin && r_decision != DEC_NONE))
        else $error("spared decision malformed");

    a_elig_le_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_elig <= r_out_live))
        else $error("eligible count above live count");
`endif

endmodule
